/* src/rc_differential_drive_mixer_core_defines.svh */
// assertion macros used by the checker file
`ifndef RC_DIFFERENTIAL_DRIVE_MIXER_CORE_DEFINES_SVH
`define RC_DIFFERENTIAL_DRIVE_MIXER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define RCDDM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RCDDM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/rcddm_pkg.sv */
package rcddm_pkg;

   // field widths
   localparam int CHANNEL_WIDTH = 11;
   localparam int GAIN_W        = 7;
   localparam int DB_W          = 9;
   localparam int PCT_W         = 8;
   localparam int DAC_W         = 8;
   localparam int MODE_W        = 2;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 9;

   // shared multiply / divide-by-100 unit widths
   localparam int OPA_W  = CHANNEL_WIDTH + GAIN_W;
   localparam int PROD_W = OPA_W + PCT_W;
   localparam int QUO_W  = PROD_W - 6;
   localparam int MREC_W = PROD_W + QUO_W;
   localparam int DIV_BASE = 100;
   localparam longint unsigned RECIP_FULL = (64'd1 << PROD_W) / DIV_BASE;
   localparam logic [QUO_W-1:0] RECIP = QUO_W'(RECIP_FULL);

   // channel thresholds
   localparam logic [CHANNEL_WIDTH-1:0] MID_VAL   = CHANNEL_WIDTH'(1500);
   localparam logic [CHANNEL_WIDTH-1:0] BRAKE_MIN = CHANNEL_WIDTH'(1000);

   // fixed percentages
   localparam logic [PCT_W-1:0] PCT_UNITY      = PCT_W'(100);
   localparam logic [PCT_W-1:0] PCT_ZERO       = PCT_W'(0);
   localparam logic [PCT_W-1:0] PCT_ONE        = PCT_W'(1);
   localparam logic [PCT_W-1:0] TURN_SPEED_PCT = PCT_W'(85);
   localparam logic [PCT_W-1:0] SPIN_LEFT_PCT  = PCT_W'(120);
   localparam logic [PCT_W-1:0] SPIN_RIGHT_PCT = PCT_W'(90);
   // 255 / 500 reduced to a percentage
   localparam logic [PCT_W-1:0] DAC_SCALE_PCT  = PCT_W'(51);
   localparam logic [DAC_W-1:0] DAC_MAX        = DAC_W'(255);

   // register reset values
   localparam logic [GAIN_W-1:0] RST_FULL_SPEED = GAIN_W'(75);
   localparam logic [GAIN_W-1:0] RST_LOW_SPEED  = GAIN_W'(55);
   localparam logic [DB_W-1:0]   RST_THR_DB     = DB_W'(25);
   localparam logic [DB_W-1:0]   RST_STEER_DB   = DB_W'(15);
   localparam logic [PCT_W-1:0]  RST_TURN_FAST  = PCT_W'(135);
   localparam logic [PCT_W-1:0]  RST_TURN_SLOW  = PCT_W'(75);
   localparam logic [PCT_W-1:0]  RST_REV_BOOST  = PCT_W'(120);
   localparam logic [PCT_W-1:0]  RST_RIGHT_BAL  = PCT_W'(115);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FULL_SPEED  = 3'd0,
      CSR_LOW_SPEED   = 3'd1,
      CSR_THR_DB      = 3'd2,
      CSR_STEER_DB    = 3'd3,
      CSR_TURN_FAST   = 3'd4,
      CSR_TURN_SLOW   = 3'd5,
      CSR_REV_BOOST   = 3'd6,
      CSR_RIGHT_BAL   = 3'd7
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_IDLE    = 2'd0,
      MODE_FORWARD = 2'd1,
      MODE_BACK    = 2'd2,
      MODE_BRAKE   = 2'd3
   } drive_mode_type;

   typedef enum logic [1:0] {
      PATH_STOP,
      PATH_MOVE,
      PATH_SPIN
   } path_type;

   typedef enum logic [3:0] {
      OP_SPD,
      OP_BOOST,
      OP_OUTER,
      OP_INNER,
      OP_TURN_MUL,
      OP_TURN_PCT,
      OP_TURN_DIV,
      OP_SPIN_L,
      OP_SPIN_R,
      OP_BAL,
      OP_DAC_L,
      OP_DAC_R
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ISSUE,
      ST_WAIT,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic   capture;
      logic   decode;
      logic   issue;
      op_type op;
      logic   load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      path_type path;
      logic     back;
      logic     turning;
      logic     step_done;
   } dp_status_type;

   typedef struct packed {
      logic             issue;
      op_type           op;
      logic             div_en;
      logic [OPA_W-1:0] a;
      logic [PCT_W-1:0] b;
   } muldiv_req_type;

   typedef struct packed {
      logic             done;
      op_type           op;
      logic [OPA_W-1:0] result;
   } muldiv_rsp_type;

endpackage

/* src/rcddm_if.sv */
// request channel: one decoded radio frame
interface rcddm_req_if;
   logic                                valid;
   logic                                ready;
   logic                                frame_valid;
   logic [rcddm_pkg::CHANNEL_WIDTH-1:0] throttle_channel;
   logic [rcddm_pkg::CHANNEL_WIDTH-1:0] steer_channel;
   logic [rcddm_pkg::CHANNEL_WIDTH-1:0] brake_channel;
   logic [rcddm_pkg::CHANNEL_WIDTH-1:0] pivot_mode_channel;
   logic [rcddm_pkg::CHANNEL_WIDTH-1:0] speed_select_channel;

   modport source (
      output valid, frame_valid, throttle_channel, steer_channel, brake_channel,
             pivot_mode_channel, speed_select_channel,
      input  ready
   );

   modport sink (
      input  valid, frame_valid, throttle_channel, steer_channel, brake_channel,
             pivot_mode_channel, speed_select_channel,
      output ready
   );
endinterface

// response channel: drive codes and lines
interface rcddm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rcddm_pkg::DAC_W-1:0]  dac_left;
   logic [rcddm_pkg::DAC_W-1:0]  dac_right;
   logic                         brake_on;
   logic                         reverse_left;
   logic                         reverse_right;
   logic [rcddm_pkg::MODE_W-1:0] drive_mode;

   modport source (
      output valid, dac_left, dac_right, brake_on, reverse_left, reverse_right,
             drive_mode,
      input  ready
   );

   modport sink (
      input  valid, dac_left, dac_right, brake_on, reverse_left, reverse_right,
             drive_mode,
      output ready
   );
endinterface

/* src/rcddm_muldiv.sv */
module rcddm_muldiv (
   input  logic                       clock,
   input  logic                       reset,
   input  rcddm_pkg::muldiv_req_type  req_in,
   output rcddm_pkg::muldiv_rsp_type  rsp_out
);
   import rcddm_pkg::*;

   logic              v1_ff, v1_in, v2_ff, v2_in;
   op_type            op1_ff, op1_in, op2_ff, op2_in;
   logic              div1_ff, div1_in, div2_ff, div2_in;
   logic [PROD_W-1:0] x1_ff, x1_in, x2_ff, x2_in;
   logic [MREC_W-1:0] m_ff, m_in;
   logic [QUO_W-1:0]  q0;
   logic [QUO_W-1:0]  q;
   logic [PROD_W-1:0] q0_times_base;
   logic [PROD_W-1:0] rem;

   // stage 1: product, stage 2: reciprocal product
   always_comb begin
      v1_in   = req_in.issue;
      op1_in  = req_in.op;
      div1_in = req_in.div_en;
      x1_in   = PROD_W'(req_in.a) * PROD_W'(req_in.b);
      v2_in   = v1_ff;
      op2_in  = op1_ff;
      div2_in = div1_ff;
      x2_in   = x1_ff;
      m_in    = MREC_W'(x1_ff) * MREC_W'(RECIP);
   end

   // stage 3: quotient estimate is low by at most one, fix with one compare
   always_comb begin
      q0            = m_ff[PROD_W +: QUO_W];
      q0_times_base = PROD_W'(q0) * PROD_W'(DIV_BASE);
      rem           = x2_ff - q0_times_base;
      q             = q0 + QUO_W'(rem >= PROD_W'(DIV_BASE));
   end

   assign rsp_out.done   = v2_ff;
   assign rsp_out.op     = op2_ff;
   assign rsp_out.result = div2_ff ? OPA_W'(q) : OPA_W'(x2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      op1_ff  <= op1_in;
      op2_ff  <= op2_in;
      div1_ff <= div1_in;
      div2_ff <= div2_in;
      x1_ff   <= x1_in;
      x2_ff   <= x2_in;
      m_ff    <= m_in;
   end

endmodule

/* src/rcddm_datapath.sv */
module rcddm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rcddm_pkg::ctrl_cmd_type             cmd,
   output rcddm_pkg::dp_status_type            status,
   input  logic                                frame_valid,
   input  logic [rcddm_pkg::CHANNEL_WIDTH-1:0] throttle_channel,
   input  logic [rcddm_pkg::CHANNEL_WIDTH-1:0] steer_channel,
   input  logic [rcddm_pkg::CHANNEL_WIDTH-1:0] brake_channel,
   input  logic [rcddm_pkg::CHANNEL_WIDTH-1:0] pivot_mode_channel,
   input  logic [rcddm_pkg::CHANNEL_WIDTH-1:0] speed_select_channel,
   input  logic                                csr_wr_en,
   input  logic [rcddm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rcddm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic [rcddm_pkg::DAC_W-1:0]         dac_left,
   output logic [rcddm_pkg::DAC_W-1:0]         dac_right,
   output logic                                brake_on,
   output logic                                reverse_left,
   output logic                                reverse_right,
   output logic [rcddm_pkg::MODE_W-1:0]        drive_mode
);
   import rcddm_pkg::*;

   // configuration registers
   logic [GAIN_W-1:0] full_ff, full_in, low_ff, low_in;
   logic [DB_W-1:0]   tdb_ff, tdb_in, sdb_ff, sdb_in;
   logic [PCT_W-1:0]  fast_ff, fast_in, slow_ff, slow_in;
   logic [PCT_W-1:0]  boost_ff, boost_in, bal_ff, bal_in;

   // captured request
   logic                     fv_ff, fv_in;
   logic [CHANNEL_WIDTH-1:0] thr_ff, thr_in, str_ff, str_in, brk_ff, brk_in;
   logic [CHANNEL_WIDTH-1:0] piv_ff, piv_in, sel_ff, sel_in;

   // held state and working values
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic              pin_l_ff, pin_l_in, pin_r_ff, pin_r_in;
   drive_mode_type    mode_ff, mode_in;
   logic              brake_ff, brake_in;
   logic [OPA_W-1:0]  spd_ff, spd_in, tmp_ff, tmp_in;
   logic [OPA_W-1:0]  lvl_l_ff, lvl_l_in, lvl_r_ff, lvl_r_in;

   // response registers
   logic [DAC_W-1:0]  out_dac_l_ff, out_dac_l_in, out_dac_r_ff, out_dac_r_in;
   logic              out_brake_ff, out_brake_in;
   logic              out_rev_l_ff, out_rev_l_in, out_rev_r_ff, out_rev_r_in;
   drive_mode_type    out_mode_ff, out_mode_in;

   // frame decode
   logic                     brake_btn, go, moving, turning, forward;
   logic                     turn_right, pivot, outer_left;
   logic [CHANNEL_WIDTH-1:0] toff, soff;
   path_type                 path;
   drive_mode_type           mode_dec;

   muldiv_req_type md_req;
   muldiv_rsp_type md_rsp;

   rcddm_muldiv u_muldiv (
      .clock   (clock),
      .reset   (reset),
      .req_in  (md_req),
      .rsp_out (md_rsp)
   );

   // decode of the captured frame
   always_comb begin
      brake_btn  = (brk_ff > BRAKE_MIN) && (brk_ff != MID_VAL);
      toff       = (thr_ff >= MID_VAL) ? thr_ff - MID_VAL : MID_VAL - thr_ff;
      soff       = (str_ff >= MID_VAL) ? str_ff - MID_VAL : MID_VAL - str_ff;
      go         = fv_ff && !brake_btn;
      moving     = toff > CHANNEL_WIDTH'(tdb_ff);
      turning    = soff > CHANNEL_WIDTH'(sdb_ff);
      forward    = thr_ff > MID_VAL;
      turn_right = str_ff > MID_VAL;
      pivot      = piv_ff < MID_VAL;
      outer_left = (turn_right == forward);
      priority if (!go) begin
         path     = PATH_STOP;
         mode_dec = MODE_BRAKE;
      end else if (moving) begin
         path     = PATH_MOVE;
         mode_dec = forward ? MODE_FORWARD : MODE_BACK;
      end else if (turning) begin
         path     = PATH_SPIN;
         mode_dec = MODE_IDLE;
      end else begin
         path     = PATH_STOP;
         mode_dec = MODE_IDLE;
      end
   end

   assign status.path      = path;
   assign status.back      = !forward;
   assign status.turning   = turning;
   assign status.step_done = md_rsp.done;

   // operand selection for the current step
   always_comb begin
      md_req.issue  = cmd.issue;
      md_req.op     = cmd.op;
      md_req.div_en = 1'b1;
      unique case (cmd.op)
         OP_SPD: begin
            md_req.a = OPA_W'(toff);
            md_req.b = PCT_W'(gain_ff);
         end
         OP_BOOST: begin
            md_req.a = spd_ff;
            md_req.b = boost_ff;
         end
         OP_OUTER: begin
            md_req.a = spd_ff;
            md_req.b = pivot ? PCT_UNITY : fast_ff;
         end
         OP_INNER: begin
            md_req.a = spd_ff;
            md_req.b = pivot ? PCT_ZERO : slow_ff;
         end
         OP_TURN_MUL: begin
            md_req.a      = OPA_W'(soff);
            md_req.b      = PCT_W'(gain_ff);
            md_req.div_en = 1'b0;
         end
         OP_TURN_PCT: begin
            md_req.a = tmp_ff;
            md_req.b = TURN_SPEED_PCT;
         end
         OP_TURN_DIV: begin
            md_req.a = tmp_ff;
            md_req.b = PCT_ONE;
         end
         OP_SPIN_L: begin
            md_req.a = tmp_ff;
            md_req.b = SPIN_LEFT_PCT;
         end
         OP_SPIN_R: begin
            md_req.a = tmp_ff;
            md_req.b = SPIN_RIGHT_PCT;
         end
         OP_BAL: begin
            md_req.a = lvl_r_ff;
            md_req.b = bal_ff;
         end
         OP_DAC_L: begin
            md_req.a = lvl_l_ff;
            md_req.b = DAC_SCALE_PCT;
         end
         OP_DAC_R: begin
            md_req.a = lvl_r_ff;
            md_req.b = DAC_SCALE_PCT;
         end
         default: begin
            md_req.a = '0;
            md_req.b = '0;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      full_in  = full_ff;
      low_in   = low_ff;
      tdb_in   = tdb_ff;
      sdb_in   = sdb_ff;
      fast_in  = fast_ff;
      slow_in  = slow_ff;
      boost_in = boost_ff;
      bal_in   = bal_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FULL_SPEED: full_in  = csr_wdata[GAIN_W-1:0];
            CSR_LOW_SPEED:  low_in   = csr_wdata[GAIN_W-1:0];
            CSR_THR_DB:     tdb_in   = csr_wdata[DB_W-1:0];
            CSR_STEER_DB:   sdb_in   = csr_wdata[DB_W-1:0];
            CSR_TURN_FAST:  fast_in  = csr_wdata[PCT_W-1:0];
            CSR_TURN_SLOW:  slow_in  = csr_wdata[PCT_W-1:0];
            CSR_REV_BOOST:  boost_in = csr_wdata[PCT_W-1:0];
            CSR_RIGHT_BAL:  bal_in   = csr_wdata[PCT_W-1:0];
            default: ;
         endcase
      end
   end

   // request capture
   always_comb begin
      fv_in  = fv_ff;
      thr_in = thr_ff;
      str_in = str_ff;
      brk_in = brk_ff;
      piv_in = piv_ff;
      sel_in = sel_ff;
      if (cmd.capture) begin
         fv_in  = frame_valid;
         thr_in = throttle_channel;
         str_in = steer_channel;
         brk_in = brake_channel;
         piv_in = pivot_mode_channel;
         sel_in = speed_select_channel;
      end
   end

   // frame state update and step write-back
   always_comb begin
      gain_in  = gain_ff;
      pin_l_in = pin_l_ff;
      pin_r_in = pin_r_ff;
      mode_in  = mode_ff;
      brake_in = brake_ff;
      spd_in   = spd_ff;
      tmp_in   = tmp_ff;
      lvl_l_in = lvl_l_ff;
      lvl_r_in = lvl_r_ff;
      if (cmd.decode) begin
         // gain kept while the selector sits exactly at mid
         if (fv_ff && (sel_ff > MID_VAL)) begin
            gain_in = low_ff;
         end else if (fv_ff && (sel_ff < MID_VAL)) begin
            gain_in = full_ff;
         end
         mode_in  = mode_dec;
         brake_in = !go;
         lvl_l_in = '0;
         lvl_r_in = '0;
         unique case (path)
            PATH_MOVE: begin
               pin_l_in = !forward;
               pin_r_in = !forward;
            end
            PATH_SPIN: begin
               pin_l_in = !turn_right;
               pin_r_in = turn_right;
            end
            default: ;
         endcase
      end else if (md_rsp.done) begin
         unique case (md_rsp.op)
            OP_SPD, OP_BOOST: begin
               spd_in   = md_rsp.result;
               lvl_l_in = md_rsp.result;
               lvl_r_in = md_rsp.result;
            end
            OP_OUTER: begin
               if (outer_left) begin
                  lvl_l_in = md_rsp.result;
               end else begin
                  lvl_r_in = md_rsp.result;
               end
            end
            OP_INNER: begin
               if (outer_left) begin
                  lvl_r_in = md_rsp.result;
               end else begin
                  lvl_l_in = md_rsp.result;
               end
            end
            OP_TURN_MUL, OP_TURN_PCT, OP_TURN_DIV: tmp_in = md_rsp.result;
            OP_SPIN_L, OP_DAC_L:                   lvl_l_in = md_rsp.result;
            OP_SPIN_R, OP_BAL, OP_DAC_R:           lvl_r_in = md_rsp.result;
            default: ;
         endcase
      end
   end

   // response load with saturation to the dac range
   always_comb begin
      out_dac_l_in = out_dac_l_ff;
      out_dac_r_in = out_dac_r_ff;
      out_brake_in = out_brake_ff;
      out_rev_l_in = out_rev_l_ff;
      out_rev_r_in = out_rev_r_ff;
      out_mode_in  = out_mode_ff;
      if (cmd.load_out) begin
         out_dac_l_in = (lvl_l_ff > OPA_W'(DAC_MAX)) ? DAC_MAX : lvl_l_ff[DAC_W-1:0];
         out_dac_r_in = (lvl_r_ff > OPA_W'(DAC_MAX)) ? DAC_MAX : lvl_r_ff[DAC_W-1:0];
         out_brake_in = brake_ff;
         out_rev_l_in = pin_l_ff;
         out_rev_r_in = pin_r_ff;
         out_mode_in  = mode_ff;
      end
   end

   assign dac_left      = out_dac_l_ff;
   assign dac_right     = out_dac_r_ff;
   assign brake_on      = out_brake_ff;
   assign reverse_left  = out_rev_l_ff;
   assign reverse_right = out_rev_r_ff;
   assign drive_mode    = out_mode_ff;

   // state with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff  <= RST_FULL_SPEED;
         low_ff   <= RST_LOW_SPEED;
         tdb_ff   <= RST_THR_DB;
         sdb_ff   <= RST_STEER_DB;
         fast_ff  <= RST_TURN_FAST;
         slow_ff  <= RST_TURN_SLOW;
         boost_ff <= RST_REV_BOOST;
         bal_ff   <= RST_RIGHT_BAL;
         gain_ff  <= RST_LOW_SPEED;
         pin_l_ff <= 1'b0;
         pin_r_ff <= 1'b0;
      end else begin
         full_ff  <= full_in;
         low_ff   <= low_in;
         tdb_ff   <= tdb_in;
         sdb_ff   <= sdb_in;
         fast_ff  <= fast_in;
         slow_ff  <= slow_in;
         boost_ff <= boost_in;
         bal_ff   <= bal_in;
         gain_ff  <= gain_in;
         pin_l_ff <= pin_l_in;
         pin_r_ff <= pin_r_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fv_ff        <= fv_in;
      thr_ff       <= thr_in;
      str_ff       <= str_in;
      brk_ff       <= brk_in;
      piv_ff       <= piv_in;
      sel_ff       <= sel_in;
      mode_ff      <= mode_in;
      brake_ff     <= brake_in;
      spd_ff       <= spd_in;
      tmp_ff       <= tmp_in;
      lvl_l_ff     <= lvl_l_in;
      lvl_r_ff     <= lvl_r_in;
      out_dac_l_ff <= out_dac_l_in;
      out_dac_r_ff <= out_dac_r_in;
      out_brake_ff <= out_brake_in;
      out_rev_l_ff <= out_rev_l_in;
      out_rev_r_ff <= out_rev_r_in;
      out_mode_ff  <= out_mode_in;
   end

endmodule

/* src/rcddm_ctrl.sv */
module rcddm_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  rcddm_pkg::dp_status_type status,
   output rcddm_pkg::ctrl_cmd_type  cmd
);
   import rcddm_pkg::*;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      out_valid_ff, out_valid_in;
   logic      load;

   // step that follows the one just finished
   function automatic op_type next_op(input op_type cur, input dp_status_type st);
      op_type nxt;
      unique case (cur)
         OP_SPD:      nxt = st.back ? OP_BOOST : (st.turning ? OP_OUTER : OP_BAL);
         OP_BOOST:    nxt = st.turning ? OP_OUTER : OP_BAL;
         OP_OUTER:    nxt = OP_INNER;
         OP_INNER:    nxt = OP_BAL;
         OP_TURN_MUL: nxt = OP_TURN_PCT;
         OP_TURN_PCT: nxt = OP_TURN_DIV;
         OP_TURN_DIV: nxt = OP_SPIN_L;
         OP_SPIN_L:   nxt = OP_SPIN_R;
         OP_SPIN_R:   nxt = OP_BAL;
         OP_BAL:      nxt = OP_DAC_L;
         OP_DAC_L:    nxt = OP_DAC_R;
         OP_DAC_R:    nxt = OP_DAC_R;
         default:     nxt = OP_DAC_R;
      endcase
      return nxt;
   endfunction

   assign load = (state_ff == ST_SEND) && (!out_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.path)
               PATH_MOVE: begin
                  state_in = ST_ISSUE;
                  op_in    = OP_SPD;
               end
               PATH_SPIN: begin
                  state_in = ST_ISSUE;
                  op_in    = OP_TURN_MUL;
               end
               default: state_in = ST_SEND;
            endcase
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (status.step_done) begin
               if (op_ff == OP_DAC_R) begin
                  state_in = ST_SEND;
               end else begin
                  state_in = ST_ISSUE;
                  op_in    = next_op(op_ff, status);
               end
            end
         end
         ST_SEND: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response register valid
   always_comb begin
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // outputs
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      rsp_valid    = out_valid_ff;
      cmd.capture  = (state_ff == ST_IDLE) && req_valid;
      cmd.decode   = (state_ff == ST_DECODE);
      cmd.issue    = (state_ff == ST_ISSUE);
      cmd.op       = op_ff;
      cmd.load_out = load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_SPD;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

/* src/rc_differential_drive_mixer_core.sv */
// Two-motor drive mixer: each request is one decoded radio frame, each response the
// left/right DAC codes, brake line, reverse lines and drive mode. A lost frame or the
// brake button answers with zero codes and brake without any arithmetic step; moving
// frames take 4 to 7 steps and idle spin frames 8 steps of a shared multiply and
// divide-by-100 unit, one step at a time, and the next request is taken as soon as
// the result sits in the response register. Configuration registers (index 0 to 7:
// full gain, low gain, throttle deadband, steer deadband, turn fast %, turn slow %,
// reverse boost %, right balance %) are written through the csr port; the user must
// write them only while idle, the block itself does not enforce it.
module rc_differential_drive_mixer_core (
   input  logic                             clock,
   input  logic                             reset,
   rcddm_req_if.sink                        req_chan,
   rcddm_rsp_if.source                      rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [rcddm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rcddm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rcddm_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer
   rcddm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // decode, arithmetic and response registers
   rcddm_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .frame_valid          (req_chan.frame_valid),
      .throttle_channel     (req_chan.throttle_channel),
      .steer_channel        (req_chan.steer_channel),
      .brake_channel        (req_chan.brake_channel),
      .pivot_mode_channel   (req_chan.pivot_mode_channel),
      .speed_select_channel (req_chan.speed_select_channel),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .dac_left             (rsp_chan.dac_left),
      .dac_right            (rsp_chan.dac_right),
      .brake_on             (rsp_chan.brake_on),
      .reverse_left         (rsp_chan.reverse_left),
      .reverse_right        (rsp_chan.reverse_right),
      .drive_mode           (rsp_chan.drive_mode)
   );

endmodule

/* src/rcddm_checker.sv */
`include "rc_differential_drive_mixer_core_defines.svh"

module rcddm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [rcddm_pkg::DAC_W-1:0]  dac_left,
   input logic [rcddm_pkg::DAC_W-1:0]  dac_right,
   input logic                         brake_on,
   input logic                         reverse_left,
   input logic                         reverse_right,
   input logic [rcddm_pkg::MODE_W-1:0] drive_mode
);
   import rcddm_pkg::*;

   // a stalled response keeps its codes, drive mode and brake line
   `RCDDM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(dac_left) && $stable(dac_right) && $stable(drive_mode) && $stable(brake_on), "stalled response changed")

   // brake line goes with brake mode
   `RCDDM_ASSERT_NOW(a_brake_mode, clock, reset, rsp_valid, brake_on == (drive_mode == MODE_BRAKE), "brake line and drive mode disagree")

   // braking never drives the motors
   `RCDDM_ASSERT_NOW(a_brake_zero, clock, reset, rsp_valid && brake_on, (dac_left == '0) && (dac_right == '0), "motor code nonzero while braking")

   // reversing drives both reverse lines
   `RCDDM_ASSERT_NOW(a_back_pins, clock, reset, rsp_valid && (drive_mode == MODE_BACK), reverse_left && reverse_right, "reverse lines not both driven in back mode")

   // one frame in work at a time
   `RCDDM_ASSERT_NEXT(a_one_at_time, clock, reset, req_valid && req_ready, !req_ready, "request taken while a frame is in work")

endmodule

bind rc_differential_drive_mixer_core rcddm_checker u_rcddm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .dac_left      (rsp_chan.dac_left),
   .dac_right     (rsp_chan.dac_right),
   .brake_on      (rsp_chan.brake_on),
   .reverse_left  (rsp_chan.reverse_left),
   .reverse_right (rsp_chan.reverse_right),
   .drive_mode    (rsp_chan.drive_mode)
);

/* verif/rc_differential_drive_mixer_core_tb.sv */
module rc_differential_drive_mixer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rcddm_pkg::*;

   localparam int          CW              = CHANNEL_WIDTH;
   localparam int unsigned CHAN_MID        = 1500;
   localparam int unsigned CHAN_MAX        = (1 << CW) - 1;
   localparam int unsigned BRAKE_THRESHOLD = 1000;
   localparam int unsigned TURN_GAIN_PCT   = 85;
   localparam int unsigned SPIN_L_PCT      = 120;
   localparam int unsigned SPIN_R_PCT      = 90;
   localparam int unsigned DAC_TOP         = 255;
   localparam int unsigned LEVEL_SPAN      = 500;
   localparam int          NUM_PHASES      = 9;
   localparam int          ITEMS_PER_PHASE = 50;
   localparam int          SETTLE_CYCLES   = 40;
   localparam int          HOLD_CYCLES     = 300;
   localparam int          DRAIN_POINT     = 25;
   localparam int          HOLD_POINT      = 5;

   // register limits, widest values and reset values, by register index
   localparam int unsigned REG_HIGH [8]     = '{100, 100, 500, 500, 200, 200, 200, 200};
   localparam int unsigned REG_WIDE_MAX [8] = '{127, 127, 511, 511, 255, 255, 255, 255};
   localparam int unsigned REG_RESET [8]    = '{75, 55, 25, 15, 135, 75, 120, 115};

   typedef struct packed {
      logic          frame_valid;
      logic [CW-1:0] throttle;
      logic [CW-1:0] steer;
      logic [CW-1:0] brake;
      logic [CW-1:0] pivot;
      logic [CW-1:0] select;
   } radio_frame_type;

   typedef struct packed {
      logic [DAC_W-1:0] dac_left;
      logic [DAC_W-1:0] dac_right;
      logic             brake_on;
      logic             reverse_left;
      logic             reverse_right;
      drive_mode_type   drive_mode;
   } drive_result_type;

   typedef struct packed {
      radio_frame_type  frame;
      logic             typed;
      drive_result_type want;
   } directed_row_type;

   localparam drive_result_type UNTYPED = '0;

   logic clock;
   logic reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rcddm_req_if req_chan ();
   rcddm_rsp_if rsp_chan ();

   rc_differential_drive_mixer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // mixer settings and state as the predictor sees them
   logic [GAIN_W-1:0] full_gain  = 7'd75;
   logic [GAIN_W-1:0] low_gain   = 7'd55;
   logic [DB_W-1:0]   thr_db     = 9'd25;
   logic [DB_W-1:0]   steer_db   = 9'd15;
   logic [PCT_W-1:0]  turn_fast  = 8'd135;
   logic [PCT_W-1:0]  turn_slow  = 8'd75;
   logic [PCT_W-1:0]  rev_boost  = 8'd120;
   logic [PCT_W-1:0]  right_bal  = 8'd115;
   logic [GAIN_W-1:0] held_gain  = 7'd55;
   logic              left_pin   = 1'b0;
   logic              right_pin  = 1'b0;

   drive_result_type pending_drive [$];
   int unsigned      fault_count     = 0;
   int unsigned      sender_idle_pct = 0;
   int unsigned      rsp_stall_pct   = 0;
   int unsigned      hold_requests   = 0;

   // directed frames: reset settings, extremes and each special case
   directed_row_type directed_rows [24] = '{
      // lost frame and brake button
      '{'{1'b0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0}, 1'b1,
        '{8'd0, 8'd0, 1'b1, 1'b0, 1'b0, MODE_BRAKE}},
      '{'{1'b1, 11'd2047, 11'd1500, 11'd1001, 11'd2047, 11'd2047}, 1'b1,
        '{8'd0, 8'd0, 1'b1, 1'b0, 1'b0, MODE_BRAKE}},
      '{'{1'b1, 11'd1500, 11'd1500, 11'd2047, 11'd1500, 11'd1500}, 1'b1,
        '{8'd0, 8'd0, 1'b1, 1'b0, 1'b0, MODE_BRAKE}},
      // brake at mid is no brake: idle straight
      '{'{1'b1, 11'd1500, 11'd1500, 11'd1500, 11'd1500, 11'd1500}, 1'b1,
        '{8'd0, 8'd0, 1'b0, 1'b0, 1'b0, MODE_IDLE}},
      // forward with selector at mid keeps low gain
      '{'{1'b1, 11'd2047, 11'd1500, 11'd1000, 11'd2047, 11'd1500}, 1'b0, UNTYPED},
      // full reverse saturates both codes
      '{'{1'b1, 11'd0, 11'd1500, 11'd0, 11'd2047, 11'd0}, 1'b1,
        '{8'd255, 8'd255, 1'b0, 1'b1, 1'b1, MODE_BACK}},
      // lost frame holds reverse lines
      '{'{1'b0, 11'd2047, 11'd0, 11'd0, 11'd0, 11'd2047}, 1'b1,
        '{8'd0, 8'd0, 1'b1, 1'b1, 1'b1, MODE_BRAKE}},
      '{'{1'b1, 11'd1510, 11'd1490, 11'd0, 11'd2047, 11'd1500}, 1'b1,
        '{8'd0, 8'd0, 1'b0, 1'b1, 1'b1, MODE_IDLE}},
      // forward turns, gentle and pivot
      '{'{1'b1, 11'd1800, 11'd1800, 11'd0, 11'd2047, 11'd0}, 1'b0, UNTYPED},
      '{'{1'b1, 11'd1800, 11'd1200, 11'd0, 11'd2047, 11'd0}, 1'b0, UNTYPED},
      '{'{1'b1, 11'd1800, 11'd1800, 11'd0, 11'd0, 11'd0}, 1'b0, UNTYPED},
      '{'{1'b1, 11'd1800, 11'd1200, 11'd0, 11'd1499, 11'd0}, 1'b0, UNTYPED},
      // reverse turns, gentle and pivot
      '{'{1'b1, 11'd1200, 11'd1800, 11'd0, 11'd1500, 11'd0}, 1'b0, UNTYPED},
      '{'{1'b1, 11'd1200, 11'd1200, 11'd0, 11'd1500, 11'd0}, 1'b0, UNTYPED},
      '{'{1'b1, 11'd1200, 11'd1800, 11'd0, 11'd0, 11'd0}, 1'b0, UNTYPED},
      '{'{1'b1, 11'd1200, 11'd1200, 11'd0, 11'd0, 11'd0}, 1'b0, UNTYPED},
      // spin in place, right then left
      '{'{1'b1, 11'd1500, 11'd2047, 11'd0, 11'd2047, 11'd0}, 1'b0, UNTYPED},
      '{'{1'b1, 11'd1500, 11'd0, 11'd0, 11'd2047, 11'd0}, 1'b0, UNTYPED},
      // deadband edges: on the band stays idle, one past moves
      '{'{1'b1, 11'd1525, 11'd1515, 11'd0, 11'd2047, 11'd0}, 1'b1,
        '{8'd0, 8'd0, 1'b0, 1'b1, 1'b0, MODE_IDLE}},
      '{'{1'b1, 11'd1526, 11'd1516, 11'd0, 11'd2047, 11'd0}, 1'b0, UNTYPED},
      '{'{1'b1, 11'd1474, 11'd1484, 11'd0, 11'd2047, 11'd0}, 1'b0, UNTYPED},
      // all ones, all zeros, then full forward on the low gain
      '{'{1'b1, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047}, 1'b1,
        '{8'd0, 8'd0, 1'b1, 1'b1, 1'b1, MODE_BRAKE}},
      '{'{1'b1, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0}, 1'b0, UNTYPED},
      '{'{1'b1, 11'd2047, 11'd1500, 11'd0, 11'd2047, 11'd2047}, 1'b0, UNTYPED}
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint unsigned mid_offset(input logic [CW-1:0] v);
      return (v >= CHAN_MID) ? longint'(v) - CHAN_MID : CHAN_MID - longint'(v);
   endfunction

   function automatic logic [DAC_W-1:0] to_dac(input longint unsigned level);
      longint unsigned code;
      code = level * DAC_TOP / LEVEL_SPAN;
      return (code > DAC_TOP) ? DAC_W'(DAC_TOP) : code[DAC_W-1:0];
   endfunction

   // drive levels for one frame; updates held gain and reverse lines
   function automatic drive_result_type mix_frame(input radio_frame_type f);
      drive_result_type r;
      longint unsigned  toff, soff, spd, tspd, outer, inner, lvl_l, lvl_r;
      logic             braking, pivot, turning, turn_right;
      lvl_l = 0;
      lvl_r = 0;
      r.brake_on = 1'b1;
      r.drive_mode = MODE_BRAKE;
      if (f.frame_valid) begin
         braking = f.brake > BRAKE_THRESHOLD && f.brake != CHAN_MID;
         toff = mid_offset(f.throttle);
         soff = mid_offset(f.steer);
         pivot = f.pivot < CHAN_MID;
         if (f.select > CHAN_MID) held_gain = low_gain;
         else if (f.select < CHAN_MID) held_gain = full_gain;
         turning = soff > steer_db;
         turn_right = f.steer > CHAN_MID;
         spd = toff * held_gain / 100;
         tspd = soff * held_gain * TURN_GAIN_PCT / 10000;
         if (braking) begin
            r.drive_mode = MODE_BRAKE;
         end else if (toff > thr_db) begin
            r.brake_on = 1'b0;
            if (f.throttle > CHAN_MID) begin
               r.drive_mode = MODE_FORWARD;
               left_pin = 1'b0;
               right_pin = 1'b0;
            end else begin
               r.drive_mode = MODE_BACK;
               left_pin = 1'b1;
               right_pin = 1'b1;
               spd = spd * rev_boost / 100;
            end
            outer = pivot ? spd : spd * turn_fast / 100;
            inner = pivot ? 0 : spd * turn_slow / 100;
            if (!turning) begin
               lvl_l = spd;
               lvl_r = spd;
            end else if (turn_right == (r.drive_mode == MODE_FORWARD)) begin
               lvl_l = outer;
               lvl_r = inner;
            end else begin
               lvl_l = inner;
               lvl_r = outer;
            end
         end else begin
            r.brake_on = 1'b0;
            r.drive_mode = MODE_IDLE;
            // spin in place: one reverse line, toward the turn
            if (turning) begin
               lvl_l = tspd * SPIN_L_PCT / 100;
               lvl_r = tspd * SPIN_R_PCT / 100;
               right_pin = turn_right;
               left_pin = !turn_right;
            end
         end
      end
      r.dac_left = to_dac(lvl_l);
      r.dac_right = to_dac(lvl_r * right_bal / 100);
      r.reverse_left = left_pin;
      r.reverse_right = right_pin;
      return r;
   endfunction

   // stick value: near the deadband edges, at the extremes or anywhere
   function automatic logic [CW-1:0] pick_channel(input int unsigned band);
      int unsigned v;
      case ($urandom_range(3))
         0: v = CHAN_MID - band - 2 + $urandom_range(2 * band + 4);
         1: case ($urandom_range(3))
               0: v = 0;
               1: v = CHAN_MAX;
               2: v = CHAN_MID;
               default: v = CHAN_MID + 1 - 2 * $urandom_range(1);
            endcase
         default: v = $urandom_range(CHAN_MAX);
      endcase
      return CW'(v);
   endfunction

   function automatic radio_frame_type random_frame();
      radio_frame_type f;
      f.frame_valid = ($urandom_range(15) != 0);
      f.throttle = pick_channel(thr_db);
      f.steer = pick_channel(steer_db);
      // mostly released so the drive paths get exercised
      case ($urandom_range(7))
         0, 1, 2, 3, 4: f.brake = CW'($urandom_range(BRAKE_THRESHOLD));
         5: f.brake = CW'(CHAN_MID);
         6: f.brake = CW'(BRAKE_THRESHOLD + $urandom_range(1));
         default: f.brake = CW'($urandom_range(CHAN_MAX));
      endcase
      f.pivot = $urandom_range(1) ? CW'($urandom_range(CHAN_MID - 1))
                                  : CW'($urandom_range(CHAN_MAX, CHAN_MID));
      f.select = ($urandom_range(3) == 0) ? CW'(CHAN_MID) : CW'($urandom_range(CHAN_MAX));
      return f;
   endfunction

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_FULL_SPEED: full_gain = value[GAIN_W-1:0];
         CSR_LOW_SPEED:  low_gain  = value[GAIN_W-1:0];
         CSR_THR_DB:     thr_db    = value[DB_W-1:0];
         CSR_STEER_DB:   steer_db  = value[DB_W-1:0];
         CSR_TURN_FAST:  turn_fast = value[PCT_W-1:0];
         CSR_TURN_SLOW:  turn_slow = value[PCT_W-1:0];
         CSR_REV_BOOST:  rev_boost = value[PCT_W-1:0];
         CSR_RIGHT_BAL:  right_bal = value[PCT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // offer one request, wait for it to be taken, then log its expectation
   task automatic push_frame(input radio_frame_type f, input logic typed,
                             input drive_result_type want);
      drive_result_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.frame_valid <= f.frame_valid;
      req_chan.throttle_channel <= f.throttle;
      req_chan.steer_channel <= f.steer;
      req_chan.brake_channel <= f.brake;
      req_chan.pivot_mode_channel <= f.pivot;
      req_chan.speed_select_channel <= f.select;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predicted = mix_frame(f);
      pending_drive.push_back(typed ? want : predicted);
   endtask

   task automatic wait_for_drain();
      do @(posedge clock); while (pending_drive.size() != 0);
   endtask

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fault_count++;
      end
   endtask

   // response side: check each accepted response, then choose next ready
   always @(posedge clock) begin : response_side
      drive_result_type want;
      int unsigned      holds_served;
      int unsigned      hold_left;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_drive.size() == 0) begin
            $error("response with no request outstanding");
            fault_count++;
         end else begin
            want = pending_drive.pop_front();
            check_field("dac_left", want.dac_left, rsp_chan.dac_left);
            check_field("dac_right", want.dac_right, rsp_chan.dac_right);
            check_field("brake_on", 8'(want.brake_on), 8'(rsp_chan.brake_on));
            check_field("reverse_left", 8'(want.reverse_left), 8'(rsp_chan.reverse_left));
            check_field("reverse_right", 8'(want.reverse_right), 8'(rsp_chan.reverse_right));
            check_field("drive_mode", 8'(want.drive_mode), 8'(rsp_chan.drive_mode));
         end
      end
      if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin : stimulus
      int unsigned value;
      req_chan.valid <= 1'b0;
      req_chan.frame_valid <= 1'b0;
      req_chan.throttle_channel <= '0;
      req_chan.steer_channel <= '0;
      req_chan.brake_channel <= '0;
      req_chan.pivot_mode_channel <= '0;
      req_chan.speed_select_channel <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames under the reset settings
      foreach (directed_rows[k])
         push_frame(directed_rows[k].frame, directed_rows[k].typed, directed_rows[k].want);
      req_chan.valid <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_for_drain();
         repeat (SETTLE_CYCLES) @(posedge clock);
         // all zero, range tops, widest values, random, then back to reset
         for (int i = 0; i < 8; i++) begin
            if (p == 0) value = 0;
            else if (p == 1) value = REG_HIGH[i];
            else if (p == 2) value = REG_WIDE_MAX[i];
            else if (p == NUM_PHASES - 1) value = REG_RESET[i];
            else value = $urandom_range(REG_HIGH[i]);
            write_register(csr_index_type'(i), CSR_DATA_W'(value));
         end
         csr_wr_en <= 1'b0;

         case (p % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 74; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 74; end
            default: begin sender_idle_pct = 11; rsp_stall_pct = 11; end
         endcase

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // long response hold-off while requests keep coming
            if (p == 2 && n == HOLD_POINT) hold_requests++;
            // sender pause until everything has come back
            if (p == 3 && n == DRAIN_POINT) begin
               req_chan.valid <= 1'b0;
               wait_for_drain();
            end
            push_frame(random_frame(), 1'b0, UNTYPED);
         end
         req_chan.valid <= 1'b0;
      end

      rsp_stall_pct = 0;
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_drive.size() == 0) begin
         $display("** rc_differential_drive_mixer_core: PASSED **");
      end else begin
         $display("** rc_differential_drive_mixer_core: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("** rc_differential_drive_mixer_core: FAILED **");
      $finish;
   end

endmodule
